// ===== rtl/cbor_scan_pkg.sv =====
// Shared types and constants for the CBOR subset item scanner.
// Depends on nothing; imported by cbor_subset_item_scanner_unit and its testbench.
package cbor_scan_pkg;

   // Nesting limit and derived widths
   localparam int MAX_NEST = 8;
   localparam int IDX_W    = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;
   localparam int LVL_W    = 4;
   localparam int ARG_W    = 64;

   // Stream widths
   localparam int REQ_TDATA_W  = 8;
   localparam int REQ_TUSER_W  = 1;
   localparam int RSP_FIELDS_W = 3 + ARG_W + 1 + LVL_W + 3;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_TDATA_W - RSP_FIELDS_W;
   localparam int RSP_TUSER_W  = 2;

   // Head decoding constants
   localparam logic [4:0]     AI_ONE_BYTE  = 5'd24;
   localparam logic [4:0]     AI_LAST_OK   = 5'd27;
   localparam logic [ARG_W-1:0] SIMPLE_FALSE = 64'd20;
   localparam logic [ARG_W-1:0] SIMPLE_NULL  = 64'd22;

   // Major types
   localparam logic [2:0] MT_BYTES = 3'd2;
   localparam logic [2:0] MT_TEXT  = 3'd3;
   localparam logic [2:0] MT_ARRAY = 3'd4;
   localparam logic [2:0] MT_MAP   = 3'd5;
   localparam logic [2:0] MT_TAG   = 3'd6;
   localparam logic [2:0] MT_OTHER = 3'd7;

   // Byte roles
   localparam logic [1:0] ROLE_INITIAL = 2'd0;
   localparam logic [1:0] ROLE_ARG     = 2'd1;
   localparam logic [1:0] ROLE_PAYLOAD = 2'd2;

   // Error codes
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_RESERVED = 3'd1;
   localparam logic [2:0] ERR_TAG      = 3'd2;
   localparam logic [2:0] ERR_SIMPLE   = 3'd3;
   localparam logic [2:0] ERR_DEEP     = 3'd4;
   localparam logic [2:0] ERR_STUCK    = 3'd5;

   // Scan phase of the byte stream
   typedef enum logic [1:0] {
      PH_INITIAL = 2'd0,
      PH_ARG     = 2'd1,
      PH_PAYLOAD = 2'd2,
      PH_DEEP    = 2'd3
   } phase_type;

   // Control sequencer
   typedef enum logic {
      CTL_IDLE = 1'b0,
      CTL_POP  = 1'b1
   } ctl_type;

   // One result item
   typedef struct packed {
      logic [1:0]       byte_role;
      logic [2:0]       major_type;
      logic [ARG_W-1:0] argument;
      logic             head_complete;
      logic [LVL_W-1:0] nesting_level;
      logic             item_complete;
      logic [2:0]       error_code;
   } rsp_type;

endpackage

// ===== rtl/cbor_subset_item_scanner_unit.sv =====
// CBOR subset item scanner: per-byte head decode and container stack tracking.
// Timing: a byte's result passes through the holding stage and then the output register;
// when a leaf closes open containers, the pop state first walks each stack level visited.
// A new byte is not accepted while the stack walk runs
// or while a result waits in the holding stage.
// Reset: synchronous, clears scan state and control; the level-count memory is not cleared.
module cbor_subset_item_scanner_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   // req_tdata: [7:0] data_byte
   input  logic [cbor_scan_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // req_tuser: [0] restart
   input  logic [cbor_scan_pkg::REQ_TUSER_W-1:0]  req_tuser,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // rsp_tdata: [2:0] major_type, [66:3] argument, [67] head_complete,
   //            [71:68] nesting_level, [74:72] error_code, [79:75] zero
   output logic [cbor_scan_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // rsp_tuser: [1:0] byte_role
   output logic [cbor_scan_pkg::RSP_TUSER_W-1:0]  rsp_tuser,
   // rsp_tlast: item_complete
   output logic                                   rsp_tlast,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready
);
   import cbor_scan_pkg::*;

   // Scan state
   phase_type        phase_ff, phase_in;
   logic [ARG_W-1:0] acc_ff, acc_in;
   logic [3:0]       left_ff, left_in;
   logic [2:0]       pend_ff, pend_in;
   logic [ARG_W-1:0] pl_ff, pl_in;
   logic [LVL_W-1:0] open_ff, open_in;
   logic             err_ff, err_in;
   ctl_type          ctl_ff, ctl_in;

   // Result holding stage and output register
   rsp_type res_ff, res_in;
   logic    res_valid_ff;
   logic    res_valid_set;
   rsp_type rsp_ff;
   logic    rsp_tvalid_ff;

   // Level-count memory
   logic [ARG_W-1:0] level_mem [MAX_NEST];
   logic [ARG_W-1:0] rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [ARG_W-1:0] mem_wdata;

   // Decode helpers
   logic             req_acc;
   logic             out_free;
   logic [LVL_W-1:0] open_m1;
   logic [LVL_W-1:0] open_m2;
   logic [7:0]       data_byte;
   logic [2:0]       byte_major;
   logic [4:0]       byte_ai;
   logic             head_fire;
   logic [2:0]       head_major;
   logic [ARG_W-1:0] head_arg;
   logic             head_direct;
   logic [ARG_W-1:0] head_cnt;
   logic             leaf;
   logic [ARG_W-1:0] cnt_dec;
   rsp_type          res_tmp;

   assign req_tready = (ctl_ff == CTL_IDLE) && !res_valid_ff;
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign open_m1    = open_ff - LVL_W'(1);
   assign open_m2    = open_ff - LVL_W'(2);
   assign data_byte  = req_tdata[7:0];
   assign byte_major = data_byte[7:5];
   assign byte_ai    = data_byte[4:0];
   assign cnt_dec    = rd_data_ff - ARG_W'(1);

   // Next state: byte scan on transfer, stack walk in the pop state
   always_comb begin
      phase_in      = phase_ff;
      acc_in        = acc_ff;
      left_in       = left_ff;
      pend_in       = pend_ff;
      pl_in         = pl_ff;
      open_in       = open_ff;
      err_in        = err_ff;
      ctl_in        = ctl_ff;
      res_in        = res_ff;
      res_valid_set = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = open_ff[IDX_W-1:0];
      mem_wdata     = '0;
      head_fire     = 1'b0;
      head_major    = '0;
      head_arg      = '0;
      head_direct   = 1'b0;
      head_cnt      = '0;
      leaf          = 1'b0;
      res_tmp       = '0;
      // prefetch the innermost count; while popping, the one below it
      rd_addr = (ctl_ff == CTL_POP) ? open_m2[IDX_W-1:0] : open_m1[IDX_W-1:0];

      case (ctl_ff)
         CTL_IDLE: begin
            if (req_acc) begin
               if (req_tuser[0]) begin
                  phase_in = PH_INITIAL;
                  acc_in   = '0;
                  left_in  = '0;
                  pend_in  = '0;
                  pl_in    = '0;
                  open_in  = '0;
                  err_in   = 1'b0;
               end
               if (err_in) begin
                  res_tmp.error_code = ERR_STUCK;
               end else begin
                  res_tmp.nesting_level = open_in;
                  case (phase_in)
                     PH_DEEP: begin
                        res_tmp.byte_role  = ROLE_INITIAL;
                        res_tmp.major_type = byte_major;
                        res_tmp.error_code = ERR_DEEP;
                        err_in             = 1'b1;
                     end
                     PH_ARG: begin
                        res_tmp.byte_role  = ROLE_ARG;
                        res_tmp.major_type = pend_in;
                        acc_in = {acc_in[ARG_W-9:0], data_byte};
                        if (left_in != 4'd0) begin
                           left_in = left_in - 4'd1;
                        end
                        if (left_in == 4'd0) begin
                           head_fire  = 1'b1;
                           head_major = pend_in;
                           head_arg   = acc_in;
                        end
                     end
                     PH_PAYLOAD: begin
                        res_tmp.byte_role  = ROLE_PAYLOAD;
                        res_tmp.major_type = pend_in;
                        if (pl_in != '0) begin
                           pl_in = pl_in - ARG_W'(1);
                        end
                        if (pl_in == '0) begin
                           phase_in = PH_INITIAL;
                           leaf     = 1'b1;
                        end
                     end
                     default: begin
                        res_tmp.byte_role  = ROLE_INITIAL;
                        res_tmp.major_type = byte_major;
                        if (byte_ai > AI_LAST_OK) begin
                           res_tmp.error_code = ERR_RESERVED;
                           err_in             = 1'b1;
                        end else if (byte_ai < AI_ONE_BYTE) begin
                           head_fire   = 1'b1;
                           head_major  = byte_major;
                           head_arg    = ARG_W'(byte_ai);
                           head_direct = 1'b1;
                        end else begin
                           pend_in  = byte_major;
                           acc_in   = '0;
                           left_in  = 4'd1 << byte_ai[1:0];
                           phase_in = PH_ARG;
                        end
                     end
                  endcase

                  // completed head: classify and push or finish
                  if (head_fire) begin
                     res_tmp.major_type    = head_major;
                     res_tmp.argument      = head_arg;
                     res_tmp.head_complete = 1'b1;
                     phase_in              = PH_INITIAL;
                     head_cnt = (head_major == MT_MAP) ? {head_arg[ARG_W-2:0], 1'b0} : head_arg;
                     if (head_major == MT_TAG) begin
                        res_tmp.error_code = ERR_TAG;
                        err_in             = 1'b1;
                     end else if (head_major == MT_OTHER &&
                                  (!head_direct || head_arg < SIMPLE_FALSE ||
                                   head_arg > SIMPLE_NULL)) begin
                        res_tmp.error_code = ERR_SIMPLE;
                        err_in             = 1'b1;
                     end else if (head_major == MT_BYTES || head_major == MT_TEXT) begin
                        if (head_arg == '0) begin
                           leaf = 1'b1;
                        end else begin
                           pl_in    = head_arg;
                           pend_in  = head_major;
                           phase_in = PH_PAYLOAD;
                        end
                     end else if (head_major == MT_ARRAY || head_major == MT_MAP) begin
                        if (head_cnt == '0) begin
                           leaf = 1'b1;
                        end else if (open_in < LVL_W'(MAX_NEST)) begin
                           mem_we    = 1'b1;
                           mem_waddr = open_in[IDX_W-1:0];
                           mem_wdata = head_cnt;
                           open_in   = open_in + LVL_W'(1);
                        end else begin
                           phase_in = PH_DEEP;
                        end
                     end else begin
                        leaf = 1'b1;
                     end
                  end

                  // finished leaf: top-level item ends or the stack walk starts
                  if (leaf) begin
                     if (open_in == '0) begin
                        res_tmp.item_complete = 1'b1;
                     end else begin
                        ctl_in = CTL_POP;
                     end
                  end
               end
               res_in = res_tmp;
               if (ctl_in == CTL_IDLE) begin
                  res_valid_set = 1'b1;
               end
            end
         end
         CTL_POP: begin
            if (cnt_dec != '0) begin
               mem_we        = 1'b1;
               mem_waddr     = open_m1[IDX_W-1:0];
               mem_wdata     = cnt_dec;
               ctl_in        = CTL_IDLE;
               res_valid_set = 1'b1;
            end else begin
               open_in = open_m1;
               if (open_ff == LVL_W'(1)) begin
                  res_in.item_complete = 1'b1;
                  ctl_in               = CTL_IDLE;
                  res_valid_set        = 1'b1;
               end
            end
         end
         default: begin
            ctl_in = CTL_IDLE;
         end
      endcase
   end

   // Control and scan registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_INITIAL;
         acc_ff        <= '0;
         left_ff       <= '0;
         pend_ff       <= '0;
         pl_ff         <= '0;
         open_ff       <= '0;
         err_ff        <= 1'b0;
         ctl_ff        <= CTL_IDLE;
         res_valid_ff  <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         left_ff  <= left_in;
         pend_ff  <= pend_in;
         pl_ff    <= pl_in;
         open_ff  <= open_in;
         err_ff   <= err_in;
         ctl_ff   <= ctl_in;
         // holding stage hands over to the output register when it frees
         if (res_valid_set) begin
            res_valid_ff <= 1'b1;
         end else if (res_valid_ff && out_free) begin
            res_valid_ff <= 1'b0;
         end
         if (res_valid_ff && out_free) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // Result payload registers
   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (res_valid_ff && out_free) begin
         rsp_ff <= res_ff;
      end
   end

   // Level-count memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         level_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= level_mem[rd_addr];
   end

   // Output packing
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_ff.error_code, rsp_ff.nesting_level,
                        rsp_ff.head_complete, rsp_ff.argument, rsp_ff.major_type};
   assign rsp_tuser  = rsp_ff.byte_role;
   assign rsp_tlast  = rsp_ff.item_complete;

`ifndef SYNTH
   // stack depth never exceeds the nesting limit
   a_open_bound: assert property (@(posedge clock) disable iff (reset)
      open_ff <= LVL_W'(MAX_NEST))
      else $error("open level count above nesting limit");

   // the stack walk only runs with at least one open level
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff == CTL_POP) |-> (open_ff != '0))
      else $error("stack walk with empty stack");

   // a held result never coexists with an unfinished stack walk
   a_pop_no_res: assert property (@(posedge clock) disable iff (reset)
      (ctl_ff == CTL_POP) |-> !res_valid_ff)
      else $error("result held during stack walk");

   // a transfer always leaves a held result or a running stack walk on the next cycle
   a_acc_result: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (res_valid_ff || ctl_ff == CTL_POP))
      else $error("accepted byte produced no pending result");
`endif

endmodule

// ===== tb/cbor_subset_item_scanner_unit_test.sv =====
// Self-checking testbench for cbor_subset_item_scanner_unit: a byte-level scan predictor,
// a clocked driver and monitor, and directed plus random CBOR streams under varied stalls.
// Depends on cbor_scan_pkg and the scanner RTL only.
module cbor_subset_item_scanner_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import cbor_scan_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE_WAIT  = 40;
   localparam int RANDOM_BYTES = 150;
   localparam int PRINT_CAP    = 100;

   // One stream byte with its restart flag (restart in the top bit)
   typedef struct packed {
      logic       restart;
      logic [7:0] data;
   } stream_byte_type;

   // Directed stream: max 8-byte uint, map with text key and empty byte string,
   // empty array, true, unassigned simple, stuck byte, tag, reserved info,
   // then nine nested arrays and a child that is one level too deep.
   localparam logic [8:0] DIRECTED_BYTES [30] = '{
      9'h11B, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF,
      9'h0A1, 9'h062, 9'h061, 9'h062, 9'h040,
      9'h080, 9'h0F5, 9'h0F7, 9'h000,
      9'h1C0,
      9'h1FF,
      9'h181, 9'h081, 9'h081, 9'h081, 9'h081, 9'h081, 9'h081, 9'h081, 9'h081,
      9'h000
   };

   logic                   clock;
   logic                   reset = 1'b1;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   rsp_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;

   stream_byte_type stream_q[$];   // bytes waiting to be offered
   stream_byte_type gen_q[$];      // bytes of the item under construction
   rsp_type         want_rsp_q[$]; // predicted results, oldest first

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_asks     = 0;
   int hold_served   = 0;
   int hold_left     = 0;

   int mismatches      = 0;
   int bytes_sent      = 0;
   int results_checked = 0;
   int items_closed    = 0;
   int error_results   = 0;
   int deepest_level   = 0;
   int idle_cycles     = 0;

   // Predictor state
   phase_type        scan_phase;
   logic [ARG_W-1:0] acc_arg;
   logic [3:0]       arg_left;
   logic [2:0]       head_major;
   logic [ARG_W-1:0] payload_rem;
   logic [ARG_W-1:0] child_left [MAX_NEST];
   logic [LVL_W-1:0] depth_open;
   logic             err_held;
   rsp_type          pred_rsp;

   cbor_subset_item_scanner_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void clear_scan();
      scan_phase  = PH_INITIAL;
      acc_arg     = '0;
      arg_left    = '0;
      head_major  = '0;
      payload_rem = '0;
      depth_open  = '0;
      err_held    = 1'b0;
   endfunction

   // Leaf done: count down the innermost level, pop every level that empties
   function automatic logic close_leaf();
      logic [IDX_W-1:0] idx;
      while (depth_open > 0) begin
         idx = IDX_W'(depth_open - 4'd1);
         child_left[idx] = child_left[idx] - 64'd1;
         if (child_left[idx] != 0)
            return 1'b0;
         depth_open = depth_open - 4'd1;
      end
      return 1'b1;
   endfunction

   // Head done: classify by major type, push containers, open payloads
   function automatic void finish_head(logic [2:0] major, logic [ARG_W-1:0] arg, logic direct);
      logic [ARG_W-1:0] cnt;
      pred_rsp.major_type    = major;
      pred_rsp.argument      = arg;
      pred_rsp.head_complete = 1'b1;
      scan_phase = PH_INITIAL;
      if (major == MT_TAG) begin
         pred_rsp.error_code = ERR_TAG;
         err_held = 1'b1;
      end else if (major == MT_OTHER && (!direct || arg < SIMPLE_FALSE || arg > SIMPLE_NULL)) begin
         pred_rsp.error_code = ERR_SIMPLE;
         err_held = 1'b1;
      end else if (major == MT_BYTES || major == MT_TEXT) begin
         if (arg == 0) begin
            pred_rsp.item_complete = close_leaf();
         end else begin
            payload_rem = arg;
            head_major  = major;
            scan_phase  = PH_PAYLOAD;
         end
      end else if (major == MT_ARRAY || major == MT_MAP) begin
         // map pair count doubles, wrapping at 64 bits
         cnt = (major == MT_ARRAY) ? arg : (arg << 1);
         if (cnt == 0) begin
            pred_rsp.item_complete = close_leaf();
         end else if (depth_open < MAX_NEST) begin
            child_left[depth_open[IDX_W-1:0]] = cnt;
            depth_open = depth_open + 4'd1;
         end else begin
            scan_phase = PH_DEEP;
         end
      end else begin
         pred_rsp.item_complete = close_leaf();
      end
   endfunction

   function automatic rsp_type scan_byte(logic [7:0] b, logic restart);
      logic [4:0] ai;
      pred_rsp = '0;
      if (restart)
         clear_scan();
      if (err_held) begin
         pred_rsp.error_code = ERR_STUCK;
         return pred_rsp;
      end
      pred_rsp.nesting_level = depth_open;
      case (scan_phase)
         PH_DEEP: begin
            pred_rsp.byte_role  = ROLE_INITIAL;
            pred_rsp.major_type = b[7:5];
            pred_rsp.error_code = ERR_DEEP;
            err_held = 1'b1;
         end
         PH_ARG: begin
            pred_rsp.byte_role  = ROLE_ARG;
            pred_rsp.major_type = head_major;
            acc_arg = {acc_arg[ARG_W-9:0], b};
            if (arg_left > 0)
               arg_left = arg_left - 4'd1;
            if (arg_left == 0)
               finish_head(head_major, acc_arg, 1'b0);
         end
         PH_PAYLOAD: begin
            pred_rsp.byte_role  = ROLE_PAYLOAD;
            pred_rsp.major_type = head_major;
            if (payload_rem > 0)
               payload_rem = payload_rem - 64'd1;
            if (payload_rem == 0) begin
               scan_phase = PH_INITIAL;
               pred_rsp.item_complete = close_leaf();
            end
         end
         default: begin
            ai = b[4:0];
            pred_rsp.byte_role  = ROLE_INITIAL;
            pred_rsp.major_type = b[7:5];
            if (ai > AI_LAST_OK) begin
               pred_rsp.error_code = ERR_RESERVED;
               err_held = 1'b1;
            end else if (ai < AI_ONE_BYTE) begin
               finish_head(b[7:5], {59'd0, ai}, 1'b1);
            end else begin
               head_major = b[7:5];
               acc_arg    = '0;
               arg_left   = 4'd1 << (ai - AI_ONE_BYTE);
               scan_phase = PH_ARG;
            end
         end
      endcase
      return pred_rsp;
   endfunction

   // ---------------------------------------------------------------- stream builder

   task automatic push_byte(logic [7:0] b);
      gen_q.push_back('{restart: 1'b0, data: b});
   endtask

   function automatic logic [63:0] rand_arg();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(4))
         0: v = v % 24;
         1: v = {56'd0, v[7:0]};
         2: v = {48'd0, v[15:0]};
         3: v = {32'd0, v[31:0]};
         default: ;
      endcase
      return v;
   endfunction

   // Head with minimal encoding most of the time, an equal or wider one otherwise
   task automatic put_head(logic [2:0] major, logic [63:0] val);
      int min_ai;
      int ai;
      int nb;
      if (val < 24)
         min_ai = 23;
      else if (val < 64'h100)
         min_ai = 24;
      else if (val < 64'h1_0000)
         min_ai = 25;
      else if (val < 64'h1_0000_0000)
         min_ai = 26;
      else
         min_ai = 27;
      if ($urandom_range(9) < 7)
         ai = min_ai;
      else
         ai = $urandom_range(27, (min_ai < 24) ? 24 : min_ai);
      if (ai < 24) begin
         push_byte({major, val[4:0]});
         return;
      end
      push_byte({major, 5'(ai)});
      nb = 1 << (ai - 24);
      for (int i = nb - 1; i >= 0; i--)
         push_byte(val[8*i +: 8]);
   endtask

   // One random data item, kept shallow except for deliberate deep chains
   task automatic gen_item(int depth);
      int kind;
      int n;
      int sv;
      kind = $urandom_range(99);
      if (depth >= 3 && kind >= 40 && kind < 80)
         kind = 0;
      if (kind < 20) begin
         put_head(3'($urandom_range(1)), rand_arg());
      end else if (kind < 40) begin
         n = $urandom_range(4);
         put_head(MT_BYTES + 3'($urandom_range(1)), 64'(n));
         repeat (n) push_byte(8'($urandom_range(255)));
      end else if (kind < 58) begin
         n = $urandom_range(3);
         put_head(MT_ARRAY, 64'(n));
         repeat (n) gen_item(depth + 1);
      end else if (kind < 72) begin
         n = $urandom_range(2);
         put_head(MT_MAP, 64'(n));
         repeat (2 * n) gen_item(depth + 1);
      end else if (kind < 75) begin
         // pair count with the top bit set: doubling wraps
         n = $urandom_range(1);
         put_head(MT_MAP, {1'b1, 62'd0, n[0]});
         repeat (2 * n) gen_item(depth + 1);
      end else if (kind < 80) begin
         if (depth == 0) begin
            n = $urandom_range(10, 6);
            repeat (n) put_head(MT_ARRAY, 64'd1);
         end
         put_head(3'd0, rand_arg());
      end else if (kind < 95) begin
         push_byte(8'hF4 + 8'($urandom_range(2)));
      end else begin
         case ($urandom_range(3))
            0: put_head(MT_TAG, rand_arg());
            1: begin
               sv = $urandom_range(23);
               if (sv >= 20 && sv <= 22)
                  sv = 23;
               push_byte({MT_OTHER, 5'(sv)});
            end
            2: begin
               sv = $urandom_range(27, 24);
               push_byte({MT_OTHER, 5'(sv)});
               repeat (1 << (sv - 24)) push_byte(8'($urandom_range(255)));
            end
            default: push_byte({3'($urandom_range(7)), 5'($urandom_range(31, 28))});
         endcase
      end
   endtask

   // Mostly well-formed items; some noise, some truncated items followed by a restart
   task automatic add_random(int count);
      int made;
      int sel;
      int cut;
      bit force_rst;
      made = 0;
      force_rst = 1'b0;
      while (made < count) begin
         gen_q.delete();
         sel = $urandom_range(99);
         if (sel < 10) begin
            repeat ($urandom_range(6, 1)) push_byte(8'($urandom_range(255)));
            foreach (gen_q[i])
               gen_q[i].restart = ($urandom_range(9) == 0);
         end else begin
            gen_item(0);
            if (force_rst || $urandom_range(1))
               gen_q[0].restart = 1'b1;
            force_rst = 1'b0;
            if (sel >= 90 && gen_q.size() > 1) begin
               cut = $urandom_range(gen_q.size() - 1, 1);
               while (gen_q.size() > cut)
                  void'(gen_q.pop_back());
               force_rst = 1'b1;
            end
         end
         foreach (gen_q[i])
            stream_q.push_back(gen_q[i]);
         made += gen_q.size();
      end
   endtask

   task automatic wait_drained();
      while (stream_q.size() != 0 || req_tvalid || want_rsp_q.size() != 0)
         @(negedge clock);
   endtask

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      if (mismatches <= PRINT_CAP)
         $display("mismatch, result %0d: %s got 0x%0h want 0x%0h",
                  results_checked, what, got, want);
   endtask

   // ---------------------------------------------------------------- driver

   // Offer the next byte when the bus is free; predict on each accepted transfer
   always @(posedge clock) begin
      stream_byte_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_tuser  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            want_rsp_q.push_back(scan_byte(req_tdata, req_tuser[0]));
            bytes_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = stream_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.data;
               req_tuser  <= nxt.restart;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   task automatic check_result();
      rsp_type want;
      if (want_rsp_q.size() == 0) begin
         report_mismatch("result with nothing expected", rsp_tdata[66:3], 64'd0);
         return;
      end
      want = want_rsp_q.pop_front();
      if (rsp_tuser != want.byte_role)
         report_mismatch("byte_role", 64'(rsp_tuser), 64'(want.byte_role));
      if (rsp_tdata[2:0] != want.major_type)
         report_mismatch("major_type", 64'(rsp_tdata[2:0]), 64'(want.major_type));
      if (rsp_tdata[66:3] != want.argument)
         report_mismatch("argument", rsp_tdata[66:3], want.argument);
      if (rsp_tdata[67] != want.head_complete)
         report_mismatch("head_complete", 64'(rsp_tdata[67]), 64'(want.head_complete));
      if (rsp_tdata[71:68] != want.nesting_level)
         report_mismatch("nesting_level", 64'(rsp_tdata[71:68]), 64'(want.nesting_level));
      if (rsp_tlast != want.item_complete)
         report_mismatch("item_complete", 64'(rsp_tlast), 64'(want.item_complete));
      if (rsp_tdata[74:72] != want.error_code)
         report_mismatch("error_code", 64'(rsp_tdata[74:72]), 64'(want.error_code));
      if (rsp_tdata[RSP_TDATA_W-1:75] != '0)
         report_mismatch("pad bits", 64'(rsp_tdata[RSP_TDATA_W-1:75]), 64'd0);
      results_checked++;
      if (want.item_complete)
         items_closed++;
      if (want.error_code != ERR_NONE)
         error_results++;
      if (int'(want.nesting_level) > deepest_level)
         deepest_level = int'(want.nesting_level);
   endtask

   // Check each result transfer; randomize ready, or hold it low on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_result();
         if (hold_served != hold_asks) begin
            hold_served = hold_asks;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Watchdog: cycles without any transfer on either side
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, want_rsp_q.size());
            $display("FAIL");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      clear_scan();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // no idling; long receiver hold-off while the sender keeps offering
      foreach (DIRECTED_BYTES[i])
         stream_q.push_back(DIRECTED_BYTES[i]);
      hold_asks++;
      add_random(RANDOM_BYTES);
      wait_drained();

      // sender idles often
      send_idle_pct = 65;
      add_random(RANDOM_BYTES);
      wait_drained();

      // receiver stalls often
      send_idle_pct = 0;
      rsp_stall_pct = 65;
      add_random(RANDOM_BYTES);
      wait_drained();

      // both sides idle now and then
      send_idle_pct = 14;
      rsp_stall_pct = 14;
      add_random(RANDOM_BYTES);
      wait_drained();

      repeat (SETTLE_WAIT) @(negedge clock);
      if (want_rsp_q.size() != 0)
         report_mismatch("results never delivered", 64'(want_rsp_q.size()), 64'd0);

      $display("scanned %0d bytes, checked %0d results: %0d top-level items closed,",
               bytes_sent, results_checked, items_closed);
      $display("%0d error results, deepest nesting level %0d, %0d mismatches",
               error_results, deepest_level, mismatches);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
